// ===== rtl/mse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mse_pkg - shared definitions for the merge sort engine
// Holds the default capacity, the element width and the controller states.
// ----------------------------------------------------------------------------
package mse_pkg;

    localparam int MSE_MAX_ITEMS = 64;
    localparam int MSE_VALUE_W   = 32;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_MERGE,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/merge_sort_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// merge_sort_engine - bottom-up merge sort over two element memories
// Collects a set of signed values, sorts them ascending and streams them back.
// ----------------------------------------------------------------------------
// Usage: send the values of a set one beat per cycle, flagging the final one
// with i_last. Up to MAX_ITEMS values are kept; further values of the set are
// discarded and every result of that set then shows o_dropped. Once the final
// beat is taken the input stalls while the set is sorted: each merge pass
// moves one element per cycle from one memory to the other, bounded by the
// single write port of the destination memory. The sorted values then leave
// one beat per cycle while i_out_ready is high, the final one flagged with
// o_last_res, and loading of the next set resumes on the cycle after that
// beat.
// ----------------------------------------------------------------------------
module merge_sort_engine #(
    parameter int MAX_ITEMS = mse_pkg::MSE_MAX_ITEMS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [mse_pkg::MSE_VALUE_W-1:0] i_value,
    input  logic                                  i_last,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [mse_pkg::MSE_VALUE_W-1:0] o_sorted_value,
    output logic                                  o_last_res,
    output logic                                  o_dropped
);
    import mse_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = CW + 2;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

    typedef logic [MSE_VALUE_W-1:0] t_word;

    // two element memories, each one write and two read ports
    t_word r_mem_a [MAX_ITEMS];
    t_word r_mem_b [MAX_ITEMS];
    t_word r_rd_a_l, r_rd_a_r, r_rd_b_l, r_rd_b_r;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          r_src, n_src;     // 0: sorted data in a, 1: in b
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_lo, n_lo;
    logic [SW-1:0] r_w, n_w;

    logic          in_beat, out_beat;
    logic [CW-1:0] cnt_new;
    t_word         src_l, src_r, merged;
    logic          take_l;
    logic          we_a, we_b;
    logic [AW-1:0] waddr;
    t_word         wdata;

    logic          start_run;
    logic [CW-1:0] st_lo;
    logic [SW-1:0] st_w;
    logic [SW-1:0] sum_m, sum_h, n_ext, next_lo, dbl_w;
    logic [CW-1:0] mid_c, hi_c;

    assign o_in_ready  = (r_state == ST_LOAD);
    assign o_out_valid = (r_state == ST_OUT);
    assign in_beat     = i_in_valid && o_in_ready;
    assign out_beat    = o_out_valid && i_out_ready;

    assign src_l  = r_src ? r_rd_b_l : r_rd_a_l;
    assign src_r  = r_src ? r_rd_b_r : r_rd_a_r;
    assign take_l = (r_i < r_mid) &&
                    ((r_j >= r_hi) || ($signed(src_l) <= $signed(src_r)));
    assign merged = take_l ? src_l : src_r;

    assign o_sorted_value = $signed(src_l);
    assign o_last_res     = (r_i == (r_count - CW'(1)));
    assign o_dropped      = r_ovf;

    assign cnt_new = (r_count < MAX_CNT) ? (r_count + CW'(1)) : r_count;
    assign n_ext   = SW'(r_count);
    assign next_lo = SW'(r_lo) + (r_w << 1);
    assign dbl_w   = r_w << 1;

    // write port: loading goes to a, merging to the memory opposite the source
    always_comb begin
        we_a  = 1'b0;
        we_b  = 1'b0;
        waddr = r_k[AW-1:0];
        wdata = merged;
        if (in_beat && (r_count < MAX_CNT)) begin
            we_a  = 1'b1;
            waddr = r_count[AW-1:0];
            wdata = i_value;
        end else if (r_state == ST_MERGE) begin
            we_a = r_src;
            we_b = !r_src;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_src     = r_src;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_mid     = r_mid;
        n_hi      = r_hi;
        n_lo      = r_lo;
        n_w       = r_w;
        start_run = 1'b0;
        st_lo     = '0;
        st_w      = r_w;

        case (r_state)
            ST_LOAD: begin
                if (in_beat) begin
                    n_count = cnt_new;
                    if (r_count >= MAX_CNT) begin
                        n_ovf = 1'b1;
                    end
                    if (i_last) begin
                        n_src = 1'b0;
                        if (cnt_new == CW'(1)) begin
                            n_state = ST_OUT;
                            n_i     = '0;
                        end else begin
                            n_state   = ST_MERGE;
                            start_run = 1'b1;
                            st_lo     = '0;
                            st_w      = SW'(1);
                        end
                    end
                end
            end
            ST_MERGE: begin
                n_k = r_k + CW'(1);
                if (take_l) begin
                    n_i = r_i + CW'(1);
                end else begin
                    n_j = r_j + CW'(1);
                end
                if ((r_k + CW'(1)) == r_hi) begin
                    if (next_lo >= n_ext) begin
                        // pass complete, data now lives in the other memory
                        n_src = !r_src;
                        if (dbl_w >= n_ext) begin
                            n_state = ST_OUT;
                            n_i     = '0;
                        end else begin
                            start_run = 1'b1;
                            st_lo     = '0;
                            st_w      = dbl_w;
                        end
                    end else begin
                        start_run = 1'b1;
                        st_lo     = next_lo[CW-1:0];
                        st_w      = r_w;
                    end
                end
            end
            ST_OUT: begin
                if (out_beat) begin
                    if (o_last_res) begin
                        n_state = ST_LOAD;
                        n_count = '0;
                        n_ovf   = 1'b0;
                    end else begin
                        n_i = r_i + CW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase

        // bounds of the run pair starting at st_lo, clipped to the set size
        sum_m = SW'(st_lo) + st_w;
        sum_h = SW'(st_lo) + (st_w << 1);
        mid_c = (sum_m < SW'(n_count)) ? sum_m[CW-1:0] : n_count;
        hi_c  = (sum_h < SW'(n_count)) ? sum_h[CW-1:0] : n_count;
        if (start_run) begin
            n_lo  = st_lo;
            n_w   = st_w;
            n_i   = st_lo;
            n_j   = mid_c;
            n_k   = st_lo;
            n_mid = mid_c;
            n_hi  = hi_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_src   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_src   <= n_src;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i   <= n_i;
        r_j   <= n_j;
        r_k   <= n_k;
        r_mid <= n_mid;
        r_hi  <= n_hi;
        r_lo  <= n_lo;
        r_w   <= n_w;
    end

    // reads follow the next indices so data lines up with the registered
    // heads; a write to the address being read is forwarded
    always_ff @(posedge i_clk) begin
        if (we_a) begin
            r_mem_a[waddr] <= wdata;
        end
        r_rd_a_l <= (we_a && (waddr == n_i[AW-1:0])) ? wdata : r_mem_a[n_i[AW-1:0]];
        r_rd_a_r <= (we_a && (waddr == n_j[AW-1:0])) ? wdata : r_mem_a[n_j[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) begin
            r_mem_b[waddr] <= wdata;
        end
        r_rd_b_l <= (we_b && (waddr == n_i[AW-1:0])) ? wdata : r_mem_b[n_i[AW-1:0]];
        r_rd_b_r <= (we_b && (waddr == n_j[AW-1:0])) ? wdata : r_mem_b[n_j[AW-1:0]];
    end

    a_merge_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MERGE) |-> ((r_k < r_hi) && (r_hi <= r_count)))
        else $error("merge index beyond run end");

    a_out_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_i < r_count))
        else $error("output index beyond set size");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("item count above capacity");

    a_last_beat_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && o_last_res) |=> (o_in_ready && (r_count == '0) && !r_ovf))
        else $error("engine not cleared after final beat");

endmodule
`default_nettype wire
